// File: src/rco_pkg.sv
// Shared types, codes and arithmetic helpers for the residue contact occupancy unit.
`default_nettype none
package rco_pkg;

	localparam int COORD_W = 20;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int IDX_W   = 8;
	localparam int CUT_W   = 30;
	localparam int LCNT_W  = 5;
	localparam int CFG_W   = 30;
	localparam int CIDX_W  = 2;
	localparam int FCNT_W  = 24;
	localparam int ACNT_W  = 32;
	localparam int TCNT_W  = 40;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_ATOM  = 2'd1;
	localparam logic [1:0] MODE_FRAME = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	localparam logic [CIDX_W-1:0] CFG_CUTOFF = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_LCOUNT = 2'd1;

	localparam logic [CUT_W-1:0]  CUTOFF_RST = 30'd9437184;
	localparam logic [LCNT_W-1:0] LCOUNT_RST = 5'd12;

	typedef logic signed [COORD_W-1:0] rco_coord_t;

	typedef struct packed {
		rco_coord_t x;
		rco_coord_t y;
		rco_coord_t z;
	} rco_pos_t;

	typedef struct packed {
		rco_pos_t         pos;
		logic [IDX_W-1:0] idx;
	} rco_atom_t;

	// squared per-axis distances from the previous cell, still to be judged
	typedef struct packed {
		logic            pend;
		logic [SQ_W-1:0] sx;
		logic [SQ_W-1:0] sy;
		logic [SQ_W-1:0] sz;
	} rco_sq_t;

	function automatic logic [SQ_W-1:0] rco_square(input rco_coord_t a, input rco_coord_t b);
		logic [COORD_W:0] d;
		logic [COORD_W:0] m;
		logic [SQ_W-1:0]  p;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		m = d[COORD_W] ? (~d + {{COORD_W{1'b0}}, 1'b1}) : d;
		p = SQ_W'(m[COORD_W-1:0]) * SQ_W'(m[COORD_W-1:0]);
		return p;
	endfunction

	function automatic logic rco_hit(input rco_sq_t sq, input logic [CUT_W-1:0] cutoff);
		logic [SQ_W+1:0] s;
		s = {2'b00, sq.sx} + {2'b00, sq.sy} + {2'b00, sq.sz};
		return sq.pend && (s <= (SQ_W+2)'(cutoff));
	endfunction

endpackage
`default_nettype wire

// File: src/residue_contact_occupancy_unit.sv
// Top level of the residue contact occupancy unit: ligand chain, residue tables, sequencer.
//
// Channel   Signals                                         Handshake
// command   start, busy, mode, index, pos_x, pos_y, pos_z   item taken when start & !busy
// result    done, residue, frames_in_contact,               done high one cycle, no stall
//           atom_contacts, total_contacts, frames_seen
// config    cfg_valid, cfg_ready, cfg_index, cfg_data       write when cfg_valid & cfg_ready
//
// Sequencing: a ligand load leaves busy low. A protein atom walks the chain of
// MAX_LIGAND cells, one cell per cycle, then reads and updates its residue entry
// before the next accept. An end of frame sweeps the frame-count table through its
// one read port and one write port. A read addresses the tables at accept and
// registers its result and done in ST_READ. After reset the residue tables are
// cleared, one entry a cycle, with busy high. Configuration is always ready.
// The result side cannot stall.
`default_nettype none
module residue_contact_occupancy_unit import rco_pkg::*; #(
	parameter int MAX_LIGAND   = 16,
	parameter int MAX_RESIDUES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         mode,
	input  wire logic [IDX_W-1:0]   index,
	input  wire rco_coord_t         pos_x,
	input  wire rco_coord_t         pos_y,
	input  wire rco_coord_t         pos_z,
	output logic                    done,
	output logic [IDX_W-1:0]        residue,
	output logic [FCNT_W-1:0]       frames_in_contact,
	output logic [ACNT_W-1:0]       atom_contacts,
	output logic [TCNT_W-1:0]       total_contacts,
	output logic [FCNT_W-1:0]       frames_seen,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data
);

	localparam int HW = $clog2(MAX_LIGAND + 1);
	localparam int RW = $clog2(MAX_RESIDUES);
	localparam int AW = (RW > IDX_W) ? RW : IDX_W;
	localparam logic [RW-1:0] SW_LAST = RW'(MAX_RESIDUES - 1);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_CHAIN  = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_SWEEP  = 3'd4;
	localparam logic [2:0] ST_DRAIN  = 3'd5;
	localparam logic [2:0] ST_READ   = 3'd6;

	logic [2:0]          state_q;
	logic [CUT_W-1:0]    cutoff_q;
	logic [LCNT_W-1:0]   lcount_q;
	logic [TCNT_W-1:0]   total_q;
	logic [FCNT_W-1:0]   frame_q;
	logic [RW-1:0]       sw_q;
	logic                wb_valid_s1;
	logic [RW-1:0]       wb_addr_s1;
	logic [HW-1:0]       fin_hits_q;
	logic [RW-1:0]       fin_addr_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic                rd_ok_q;
	logic                done_q;
	logic [IDX_W-1:0]    residue_q;
	logic [FCNT_W-1:0]   fic_q;
	logic [ACNT_W-1:0]   ac_q;
	logic [TCNT_W-1:0]   tc_q;
	logic [FCNT_W-1:0]   fs_q;

	// residue tables: {frame hit flag, frame count} and atom contact count
	logic [FCNT_W:0]     fmem_q [MAX_RESIDUES];
	logic [ACNT_W-1:0]   cmem_q [MAX_RESIDUES];
	logic [FCNT_W:0]     frd_q;
	logic [ACNT_W-1:0]   crd_q;

	logic                accept;
	logic                res_ok;
	logic                launch;
	logic [AW-1:0]       in_ext;
	logic [AW-1:0]       tail_ext;
	logic [RW-1:0]       in_addr;
	logic [RW-1:0]       tail_addr;
	logic [HW-1:0]       tail_hits;
	logic [RW-1:0]       rd_addr;
	logic [RW-1:0]       w_addr;
	logic                f_we;
	logic                c_we;
	logic [FCNT_W:0]     f_wdata;
	logic [ACNT_W-1:0]   c_wdata;
	logic [ACNT_W:0]     c_sum;
	logic [TCNT_W:0]     t_sum;
	logic [ACNT_W-1:0]   c_new;
	logic [TCNT_W-1:0]   t_new;
	logic [FCNT_W-1:0]   f_inc;
	logic [FCNT_W-1:0]   frame_inc;
	rco_pos_t            in_pos;

	logic                valid_c [MAX_LIGAND+1];
	rco_atom_t           atom_c  [MAX_LIGAND+1];
	logic [HW-1:0]       hits_c  [MAX_LIGAND+1];
	rco_sq_t             sq_c    [MAX_LIGAND+1];

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign res_ok    = (32'(index) < MAX_RESIDUES);
	assign launch    = accept && (mode == MODE_ATOM) && res_ok;

	assign in_ext    = AW'(index);
	assign in_addr   = in_ext[RW-1:0];
	assign in_pos    = '{x: pos_x, y: pos_y, z: pos_z};

	// chain entry: the atom enters with no pending distances
	assign valid_c[0] = launch;
	assign atom_c[0]  = '{pos: in_pos, idx: index};
	assign hits_c[0]  = '0;
	assign sq_c[0]    = '0;

	for (genvar k = 0; k < MAX_LIGAND; k++) begin : g_cell
		logic ld_en;
		logic active;
		assign ld_en  = accept && (mode == MODE_LOAD) && (32'(index) == k);
		assign active = (32'(lcount_q) > k);
		rco_cell #(.HW(HW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ld_en     (ld_en),
			.ld_pos    (in_pos),
			.active    (active),
			.cutoff    (cutoff_q),
			.in_valid  (valid_c[k]),
			.in_atom   (atom_c[k]),
			.in_hits   (hits_c[k]),
			.in_sq     (sq_c[k]),
			.out_valid (valid_c[k+1]),
			.out_atom  (atom_c[k+1]),
			.out_hits  (hits_c[k+1]),
			.out_sq    (sq_c[k+1])
		);
	end

	// judge the last ligand at the chain tail
	assign tail_hits = hits_c[MAX_LIGAND] + HW'(rco_hit(sq_c[MAX_LIGAND], cutoff_q));
	assign tail_ext  = AW'(atom_c[MAX_LIGAND].idx);
	assign tail_addr = tail_ext[RW-1:0];

	// saturating updates
	assign c_sum     = {1'b0, crd_q} + (ACNT_W+1)'(fin_hits_q);
	assign c_new     = c_sum[ACNT_W] ? {ACNT_W{1'b1}} : c_sum[ACNT_W-1:0];
	assign t_sum     = {1'b0, total_q} + (TCNT_W+1)'(fin_hits_q);
	assign t_new     = t_sum[TCNT_W] ? {TCNT_W{1'b1}} : t_sum[TCNT_W-1:0];
	assign f_inc     = frd_q[FCNT_W] ?
		((&frd_q[FCNT_W-1:0]) ? frd_q[FCNT_W-1:0] : frd_q[FCNT_W-1:0] + 1'b1) :
		frd_q[FCNT_W-1:0];
	assign frame_inc = (&frame_q) ? frame_q : frame_q + 1'b1;

	always_comb begin
		case (state_q)
			ST_IDLE:  rd_addr = in_addr;
			ST_CHAIN: rd_addr = tail_addr;
			default:  rd_addr = sw_q;
		endcase
	end

	always_comb begin
		f_we    = 1'b0;
		c_we    = 1'b0;
		w_addr  = sw_q;
		f_wdata = '0;
		c_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				f_we = 1'b1;
				c_we = 1'b1;
			end
			ST_UPDATE: begin
				f_we    = 1'b1;
				c_we    = 1'b1;
				w_addr  = fin_addr_q;
				f_wdata = {frd_q[FCNT_W] | (fin_hits_q != '0), frd_q[FCNT_W-1:0]};
				c_wdata = c_new;
			end
			default: ;
		endcase
		// frame sweep write-back comes in the cycle after its read; drop the flag
		if (wb_valid_s1) begin
			f_we    = 1'b1;
			w_addr  = wb_addr_s1;
			f_wdata = {1'b0, f_inc};
		end
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			fmem_q[w_addr] <= f_wdata;
		end
		frd_q <= fmem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (c_we) begin
			cmem_q[w_addr] <= c_wdata;
		end
		crd_q <= cmem_q[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RST;
			lcount_q <= LCOUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CUTOFF: cutoff_q <= cfg_data[CUT_W-1:0];
				CFG_LCOUNT: lcount_q <= cfg_data[LCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sw_q        <= '0;
			wb_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
			total_q     <= '0;
			frame_q     <= '0;
		end else begin
			done_q      <= 1'b0;
			wb_valid_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (sw_q == SW_LAST) begin
						sw_q    <= '0;
						state_q <= ST_IDLE;
					end else begin
						sw_q <= sw_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (start) begin
						case (mode)
							MODE_ATOM: begin
								if (res_ok) begin
									state_q <= ST_CHAIN;
								end
							end
							MODE_FRAME: begin
								sw_q    <= '0;
								frame_q <= frame_inc;
								state_q <= ST_SWEEP;
							end
							MODE_READ: state_q <= ST_READ;
							default: ;
						endcase
					end
				end
				ST_CHAIN: begin
					if (valid_c[MAX_LIGAND]) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					total_q <= t_new;
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					wb_valid_s1 <= 1'b1;
					if (sw_q == SW_LAST) begin
						sw_q    <= '0;
						state_q <= ST_DRAIN;
					end else begin
						sw_q <= sw_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_IDLE;
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: hold tail results, read request and result fields
	always_ff @(posedge clk) begin
		wb_addr_s1 <= sw_q;
		fin_hits_q <= tail_hits;
		fin_addr_q <= tail_addr;
		if (accept) begin
			rd_idx_q <= index;
			rd_ok_q  <= res_ok;
		end
		if (state_q == ST_READ) begin
			residue_q <= rd_idx_q;
			fic_q     <= rd_ok_q ? frd_q[FCNT_W-1:0] : '0;
			ac_q      <= rd_ok_q ? crd_q : '0;
			tc_q      <= total_q;
			fs_q      <= frame_q;
		end
	end

	assign done              = done_q;
	assign residue           = residue_q;
	assign frames_in_contact = fic_q;
	assign atom_contacts     = ac_q;
	assign total_contacts    = tc_q;
	assign frames_seen       = fs_q;

endmodule
`default_nettype wire

// File: src/rco_cell.sv
// One cell of the ligand chain: holds a ligand atom, squares its distances to the passing protein atom.
`default_nettype none
module rco_cell import rco_pkg::*; #(
	parameter int HW = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              ld_en,
	input  wire rco_pos_t          ld_pos,
	input  wire logic              active,
	input  wire logic [CUT_W-1:0]  cutoff,
	input  wire logic              in_valid,
	input  wire rco_atom_t         in_atom,
	input  wire logic [HW-1:0]     in_hits,
	input  wire rco_sq_t           in_sq,
	output logic                   out_valid,
	output rco_atom_t              out_atom,
	output logic [HW-1:0]          out_hits,
	output rco_sq_t                out_sq
);

	rco_pos_t lig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	// judge the previous cell's distances, square our own for the next cell
	always_ff @(posedge clk) begin
		if (ld_en) begin
			lig_q <= ld_pos;
		end
		out_atom  <= in_atom;
		out_hits  <= in_hits + HW'(rco_hit(in_sq, cutoff));
		out_sq.pend <= active;
		out_sq.sx <= rco_square(lig_q.x, in_atom.pos.x);
		out_sq.sy <= rco_square(lig_q.y, in_atom.pos.y);
		out_sq.sz <= rco_square(lig_q.z, in_atom.pos.z);
	end

endmodule
`default_nettype wire

// File: tb/residue_contact_occupancy_unit_test.sv
// Self-checking bench for residue_contact_occupancy_unit: predicts every read and compares it.
module residue_contact_occupancy_unit_test;
	import rco_pkg::*;

	localparam int NUM_SLOTS    = 16;
	localparam int NUM_RES      = 256;
	// An end of frame sweeps the whole residue table; give it plus a margin before any
	// register write or the final verdict.
	localparam int SETTLE_CYCLES = NUM_RES + 2 * NUM_SLOTS + 8;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam longint COORD_HI  = 524287;
	localparam longint COORD_LO  = -524288;

	// one command as it sits in the send queue
	typedef struct packed {
		logic [1:0]       mode;
		logic [IDX_W-1:0] idx;
		rco_coord_t       x;
		rco_coord_t       y;
		rco_coord_t       z;
	} command_t;

	// one residue report as the block should give it
	typedef struct packed {
		logic [IDX_W-1:0]  residue;
		logic [FCNT_W-1:0] frames;
		logic [ACNT_W-1:0] atoms;
		logic [TCNT_W-1:0] total;
		logic [FCNT_W-1:0] seen;
	} occupancy_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         mode = MODE_LOAD;
	logic [IDX_W-1:0]   index = '0;
	rco_coord_t         pos_x = '0;
	rco_coord_t         pos_y = '0;
	rco_coord_t         pos_z = '0;
	logic               done;
	logic [IDX_W-1:0]   residue;
	logic [FCNT_W-1:0]  frames_in_contact;
	logic [ACNT_W-1:0]  atom_contacts;
	logic [TCNT_W-1:0]  total_contacts;
	logic [FCNT_W-1:0]  frames_seen;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index = CFG_CUTOFF;
	logic [CFG_W-1:0]   cfg_data = '0;

	residue_contact_occupancy_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.index(index),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.done(done),
		.residue(residue),
		.frames_in_contact(frames_in_contact),
		.atom_contacts(atom_contacts),
		.total_contacts(total_contacts),
		.frames_seen(frames_seen),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Predicted contents of the block: ligand store, per-residue tables, global counters
	// and the two registers.
	rco_coord_t         slot_x [NUM_SLOTS];
	rco_coord_t         slot_y [NUM_SLOTS];
	rco_coord_t         slot_z [NUM_SLOTS];
	logic               frame_mark [NUM_RES];
	logic [FCNT_W-1:0]  frame_tally [NUM_RES];
	logic [ACNT_W-1:0]  atom_tally [NUM_RES];
	logic [TCNT_W-1:0]  contact_total = '0;
	logic [FCNT_W-1:0]  frames_closed = '0;
	logic [CUT_W-1:0]   cutoff_sq = CUTOFF_RST;
	logic [LCNT_W-1:0]  ligand_n = LCOUNT_RST;

	command_t   pending_cmds [$];
	occupancy_t expected_reads [$];

	int error_count = 0;
	int results_checked = 0;
	int accepted_by_mode [4] = '{0, 0, 0, 0};
	int hot_res [8];

	logic item_taken;
	int   burst_left = 1;
	int   gap_left = 0;
	int   cycle_count = 0;

	initial begin
		for (int r = 0; r < NUM_RES; r++) begin
			frame_mark[r] = 1'b0;
			frame_tally[r] = '0;
			atom_tally[r] = '0;
		end
		for (int k = 0; k < NUM_SLOTS; k++) begin
			slot_x[k] = '0;
			slot_y[k] = '0;
			slot_z[k] = '0;
		end
	end

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic longint unsigned axis_sq(rco_coord_t a, rco_coord_t b);
		longint d;
		d = longint'(a) - longint'(b);
		return longint'(d * d);
	endfunction

	// Fold one accepted command into the predicted state; a read queues its report.
	task automatic account_item(logic [1:0] m, logic [IDX_W-1:0] idx,
			rco_coord_t x, rco_coord_t y, rco_coord_t z);
		int n;
		longint unsigned d2;
		occupancy_t rep;
		accepted_by_mode[m]++;
		case (m)
			MODE_LOAD: begin
				// slots past the store are dropped
				if (idx < NUM_SLOTS) begin
					slot_x[idx] = x;
					slot_y[idx] = y;
					slot_z[idx] = z;
				end
			end
			MODE_ATOM: begin
				// a count above the store size compares the whole store; zero compares none
				n = (ligand_n > NUM_SLOTS) ? NUM_SLOTS : int'(ligand_n);
				for (int k = 0; k < n; k++) begin
					d2 = axis_sq(slot_x[k], x) + axis_sq(slot_y[k], y) + axis_sq(slot_z[k], z);
					if (d2 <= longint'(cutoff_sq)) begin
						if (atom_tally[idx] != '1)
							atom_tally[idx] = atom_tally[idx] + 1'b1;
						if (contact_total != '1)
							contact_total = contact_total + 1'b1;
						frame_mark[idx] = 1'b1;
					end
				end
			end
			MODE_FRAME: begin
				for (int r = 0; r < NUM_RES; r++) begin
					if (frame_mark[r] && frame_tally[r] != '1)
						frame_tally[r] = frame_tally[r] + 1'b1;
					frame_mark[r] = 1'b0;
				end
				if (frames_closed != '1)
					frames_closed = frames_closed + 1'b1;
			end
			default: begin
				rep.residue = idx;
				rep.frames  = frame_tally[idx];
				rep.atoms   = atom_tally[idx];
				rep.total   = contact_total;
				rep.seen    = frames_closed;
				expected_reads.push_back(rep);
			end
		endcase
	endtask

	task automatic compare_field(string field, logic [63:0] got, logic [63:0] want,
			logic [IDX_W-1:0] res);
		if (got !== want)
			report_mismatch($sformatf("residue %0d %s: got %0d, expected %0d",
				res, field, got, want));
	endtask

	task automatic check_report();
		occupancy_t want;
		if (expected_reads.size() == 0) begin
			report_mismatch($sformatf("report for residue %0d with no read waiting", residue));
		end else begin
			want = expected_reads.pop_front();
			results_checked++;
			compare_field("residue", 64'(residue), 64'(want.residue), want.residue);
			compare_field("frames_in_contact", 64'(frames_in_contact), 64'(want.frames),
				want.residue);
			compare_field("atom_contacts", 64'(atom_contacts), 64'(want.atoms), want.residue);
			compare_field("total_contacts", 64'(total_contacts), 64'(want.total), want.residue);
			compare_field("frames_seen", 64'(frames_seen), 64'(want.seen), want.residue);
		end
	endtask

	// Sample at the rising edge: check a report first (it belongs to an earlier read),
	// then take in the command accepted at this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			if (done === 1'b1)
				check_report();
			item_taken <= start && !busy;
			if (start && !busy)
				account_item(mode, index, pos_x, pos_y, pos_z);
		end
	end

	// Present commands at the falling edge. Hold the current one until it is taken; then
	// advance to the next, or drop start for a gap between bursts.
	always @(negedge clk) begin
		command_t cmd;
		if (arst_n && (!start || item_taken)) begin
			if (pending_cmds.size() == 0 || gap_left > 0) begin
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				start <= 1'b0;
			end else begin
				cmd = pending_cmds.pop_front();
				start <= 1'b1;
				mode  <= cmd.mode;
				index <= cmd.idx;
				pos_x <= cmd.x;
				pos_y <= cmd.y;
				pos_z <= cmd.z;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d reports outstanding",
				expected_reads.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_cmd(logic [1:0] m, logic [IDX_W-1:0] idx,
			rco_coord_t x, rco_coord_t y, rco_coord_t z);
		command_t c;
		c.mode = m;
		c.idx  = idx;
		c.x    = x;
		c.y    = y;
		c.z    = z;
		pending_cmds.push_back(c);
	endtask

	function automatic int cutoff_root(longint unsigned v);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (longint'(mid) * mid <= v)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	// Move a coordinate by up to +/- spread, clamped to the field range.
	function automatic rco_coord_t near_coord(rco_coord_t c, int spread);
		longint v;
		v = longint'(c) + longint'($urandom_range(0, 2 * spread)) - spread;
		if (v > COORD_HI)
			v = COORD_HI;
		else if (v < COORD_LO)
			v = COORD_LO;
		return rco_coord_t'(v);
	endfunction

	// Fill the send queue with n effective commands. Most atoms land on or near a ligand
	// slot so that contacts are frequent; the rest are spread over the full range.
	task automatic queue_random(int n);
		int effective;
		int pick;
		int spread;
		int active;
		int k;
		logic [IDX_W-1:0] idx;
		rco_coord_t x;
		rco_coord_t y;
		rco_coord_t z;
		effective = 0;
		spread = cutoff_root(longint'(cutoff_sq)) + 2;
		active = (ligand_n == 0) ? NUM_SLOTS : ((ligand_n > NUM_SLOTS) ? NUM_SLOTS : ligand_n);
		while (effective < n) begin
			pick = $urandom_range(0, 99);
			x = rco_coord_t'($urandom);
			y = rco_coord_t'($urandom);
			z = rco_coord_t'($urandom);
			if (pick < 10) begin
				idx = ($urandom_range(0, 6) == 0) ? IDX_W'($urandom_range(NUM_SLOTS, 255))
					: IDX_W'($urandom_range(0, NUM_SLOTS - 1));
				// cluster most ligand atoms so one protein atom can touch several
				if ($urandom_range(0, 4) < 3) begin
					k = $urandom_range(0, NUM_SLOTS - 1);
					x = near_coord(slot_x[k], spread);
					y = near_coord(slot_y[k], spread);
					z = near_coord(slot_z[k], spread);
				end
				queue_cmd(MODE_LOAD, idx, x, y, z);
				if (idx < NUM_SLOTS)
					effective++;
			end else if (pick < 62) begin
				idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 255))
					: IDX_W'(hot_res[$urandom_range(0, 7)]);
				if ($urandom_range(0, 4) != 0) begin
					k = $urandom_range(0, active - 1);
					if ($urandom_range(0, 4) == 0) begin
						x = slot_x[k];
						y = slot_y[k];
						z = slot_z[k];
					end else begin
						x = near_coord(slot_x[k], spread);
						y = near_coord(slot_y[k], spread);
						z = near_coord(slot_z[k], spread);
					end
				end
				queue_cmd(MODE_ATOM, idx, x, y, z);
				effective++;
			end else if (pick < 70) begin
				queue_cmd(MODE_FRAME, IDX_W'($urandom), x, y, z);
				effective++;
			end else begin
				idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 255))
					: IDX_W'(hot_res[$urandom_range(0, 7)]);
				queue_cmd(MODE_READ, idx, x, y, z);
				effective++;
			end
		end
	endtask

	// Wait until every command is taken and every report is in, then let the longest
	// operation run out so the block is idle.
	task automatic wait_idle();
		while (pending_cmds.size() != 0 || start || expected_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CIDX_W-1:0] reg_idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (reg_idx == CFG_CUTOFF)
			cutoff_sq = value[CUT_W-1:0];
		else if (reg_idx == CFG_LCOUNT)
			ligand_n = value[LCNT_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reprogram both registers on an idle block, then send a random batch.
	task automatic run_phase(logic [CUT_W-1:0] cut, logic [LCNT_W-1:0] lcount, int n);
		logic [CFG_W-1:0] lword;
		wait_idle();
		write_register(CFG_CUTOFF, CFG_W'(cut));
		// upper bits of the count word are noise the register must drop
		lword = CFG_W'($urandom);
		lword[LCNT_W-1:0] = lcount;
		write_register(CFG_LCOUNT, lword);
		queue_random(n);
	endtask

	initial begin
		hot_res[0] = 0;
		hot_res[1] = 255;
		for (int h = 2; h < 8; h++)
			hot_res[h] = $urandom_range(1, 254);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset register values (cutoff of 3 A, 12 slots compared).
		// Fill every slot before any atom: slot 0 at the origin, slots 1 and 2 at the
		// corners of the range, slot 12 duplicates slot 0 but stays outside the count.
		queue_cmd(MODE_LOAD, 0, 0, 0, 0);
		queue_cmd(MODE_LOAD, 1, rco_coord_t'(COORD_HI), rco_coord_t'(COORD_HI),
			rco_coord_t'(COORD_HI));
		queue_cmd(MODE_LOAD, 2, rco_coord_t'(COORD_LO), rco_coord_t'(COORD_LO),
			rco_coord_t'(COORD_LO));
		for (int s = 3; s < NUM_SLOTS; s++) begin
			if (s == 12)
				queue_cmd(MODE_LOAD, IDX_W'(s), 0, 0, 0);
			else
				queue_cmd(MODE_LOAD, IDX_W'(s), rco_coord_t'($urandom),
					rco_coord_t'($urandom), rco_coord_t'($urandom));
		end
		// a slot past the store is ignored
		queue_cmd(MODE_LOAD, 200, 0, 0, 0);
		// exactly on the cutoff counts, one step beyond does not
		queue_cmd(MODE_ATOM, 0, 3072, 0, 0);
		queue_cmd(MODE_ATOM, 1, 0, 3073, 0);
		// zero distance at one corner, largest differences from the other corner
		queue_cmd(MODE_ATOM, 255, rco_coord_t'(COORD_HI), rco_coord_t'(COORD_HI),
			rco_coord_t'(COORD_HI));
		queue_cmd(MODE_ATOM, 2, rco_coord_t'(COORD_LO), rco_coord_t'(COORD_HI),
			rco_coord_t'(COORD_LO));
		queue_cmd(MODE_FRAME, 0, 0, 0, 0);
		queue_cmd(MODE_READ, 0, 0, 0, 0);
		queue_cmd(MODE_READ, 1, 0, 0, 0);
		queue_cmd(MODE_READ, 255, 0, 0, 0);
		queue_cmd(MODE_READ, 2, 0, 0, 0);

		// Register extremes first, then random settings.
		run_phase('0, 5'd16, 60);
		run_phase('1, 5'd31, 80);
		run_phase(CUTOFF_RST, 5'd0, 40);
		run_phase(CUT_W'($urandom_range(0, 1 << 24)), 5'd1, 80);
		repeat (4)
			run_phase(($urandom_range(0, 3) == 0) ? CUT_W'($urandom)
				: CUT_W'($urandom_range(0, 1 << 24)),
				LCNT_W'($urandom_range(1, NUM_SLOTS)), 85);

		wait_idle();
		if (expected_reads.size() != 0)
			report_mismatch($sformatf("%0d reads never reported", expected_reads.size()));
		$display("Accepted %0d ligand loads, %0d protein atoms, %0d frame ends, %0d reads",
			accepted_by_mode[MODE_LOAD], accepted_by_mode[MODE_ATOM],
			accepted_by_mode[MODE_FRAME], accepted_by_mode[MODE_READ]);
		$display("Checked %0d reports; %0d contacts over %0d frames; %0d mismatches",
			results_checked, contact_total, frames_closed, error_count);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
